@@ rtl/chrt_pkg.sv @@
// chrt_pkg: request, response and queued job types for the route table
// no dependencies; imported by every module of chained_hash_route_table_core
`default_nettype none

package chrt_pkg;

    localparam int KEY_W = 8;
    localparam int HOP_W = 8;

    typedef enum logic
    {
        OP_SET    = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef struct packed
    {
        logic               operation;
        logic [KEY_W-1:0]   dest_node;
        logic [HOP_W-1:0]   next_hop_in;
    } req_t;

    typedef struct packed
    {
        logic [HOP_W-1:0]   next_hop_out;
        logic               found;
        logic               table_full;
    } rsp_t;

    // slot index fits 8 bits since it is the 8-bit key modulo the slot count
    typedef struct packed
    {
        req_t               req;
        logic [KEY_W-1:0]   slot;
    } job_t;

    typedef struct packed
    {
        logic               valid;
        job_t               job;
    } job_chan_t;

endpackage

`default_nettype wire

@@ rtl/chained_hash_route_table_core.sv @@
// chained_hash_route_table_core: next-hop table, hashed slots chained through an entry pool
// a job reads its slot head in ST_HEAD, then visits one chain entry per ST_WALK step and, when
// a new entry is appended behind a chain tail, passes through ST_LINK; the result is registered
// the back end takes a new job only when idle, so jobs do not overlap in the one-read pool walk
// reset clears queue, result valid, slot head valid flags and fill count at once; pool contents
// are left unwritten and need no clearing pass, requests are taken right after reset
`default_nettype none

module chained_hash_route_table_core
    import chrt_pkg::*;
#(
    parameter int SLOTS        = 16,
    parameter int POOL_ENTRIES = 64
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    output logic        req_ready,
    input  wire req_t   req,
    output logic        rsp_valid,
    input  wire logic   rsp_ready,
    output rsp_t        rsp
);

    job_chan_t  job_chan;
    logic       job_ready;

    chrt_front #(
        .SLOTS      (SLOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .job_out    (job_chan),
        .job_ready  (job_ready)
    );

    chrt_back #(
        .SLOTS        (SLOTS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_in     (job_chan),
        .job_ready  (job_ready),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

@@ rtl/chrt_front.sv @@
// chrt_front: request intake, slot hashing and a two-entry job queue
// depends on chrt_pkg; feeds chrt_back
`default_nettype none

module chrt_front
    import chrt_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_ready,
    input  wire req_t       req,
    output job_chan_t       job_out,
    input  wire logic       job_ready
);

    localparam int KEYS = 1 << KEY_W;

    logic [KEY_W-1:0] slot_lut [KEYS];

    genvar gi;
    generate
        for (gi = 0; gi < KEYS; gi++)
        begin : g_lut
            assign slot_lut[gi] = KEY_W'(gi % SLOTS);
        end
    endgenerate

    job_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign req_ready       = (count_reg != 2'd2);
    assign push            = req_valid && req_ready;
    assign pop             = job_out.valid && job_ready;
    assign job_out.valid   = (count_reg != 2'd0);
    assign job_out.job     = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].req  <= req;
            q_reg[wr_ptr_reg].slot <= slot_lut[req.dest_node];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chrt_back.sv @@
// chrt_back: chain walk over slot head and entry pool memories, result register
// depends on chrt_pkg; takes jobs from chrt_front
`default_nettype none

module chrt_back
    import chrt_pkg::*;
#(
    parameter int SLOTS        = 16,
    parameter int POOL_ENTRIES = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire job_chan_t  job_in,
    output logic            job_ready,
    output logic            rsp_valid,
    input  wire logic       rsp_ready,
    output rsp_t            rsp
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(POOL_ENTRIES + 1);

    typedef struct packed
    {
        logic [KEY_W-1:0]   dest;
        logic [HOP_W-1:0]   hop;
        logic               link_ok;
        logic [PTR_W-1:0]   link;
    } entry_t;

    typedef enum logic [3:0]
    {
        ST_IDLE = 4'b0001,
        ST_HEAD = 4'b0010,
        ST_WALK = 4'b0100,
        ST_LINK = 4'b1000
    } state_t;

    logic [PTR_W-1:0]   head_mem [SLOTS];
    entry_t             ent_mem [POOL_ENTRIES];

    state_t             state_reg;
    state_t             state_next;
    job_t               job_reg;
    logic [PTR_W-1:0]   cur_reg;
    logic [PTR_W-1:0]   cur_next;
    logic [PTR_W-1:0]   fresh_reg;
    logic [PTR_W-1:0]   fresh_next;
    entry_t             tail_reg;
    entry_t             tail_next;
    logic [CNT_W-1:0]   used_reg;
    logic [CNT_W-1:0]   used_next;
    logic [SLOTS-1:0]   head_ok_reg;
    logic [SLOTS-1:0]   head_ok_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic [PTR_W-1:0]   head_q;
    entry_t             ent_q;
    logic [PTR_W-1:0]   ent_ra;
    logic               ent_we;
    logic [PTR_W-1:0]   ent_wa;
    entry_t             ent_wd;
    logic               head_we;

    logic [SLOT_W-1:0]  slot;
    logic               start;
    logic               is_lookup;
    logic               pool_full;
    logic               hit;
    entry_t             new_ent;

    assign slot      = job_reg.slot[SLOT_W-1:0];
    assign start     = (state_reg == ST_IDLE) && job_in.valid
                       && (!rsp_valid_reg || rsp_ready);
    assign job_ready = start;
    assign is_lookup = (job_reg.req.operation == OP_LOOKUP);
    assign pool_full = (used_reg == CNT_W'(POOL_ENTRIES));
    assign hit       = (ent_q.dest == job_reg.req.dest_node);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        new_ent.dest    = job_reg.req.dest_node;
        new_ent.hop     = job_reg.req.next_hop_in;
        new_ent.link_ok = 1'b0;
        new_ent.link    = '0;
    end

    assign ent_ra = (state_reg == ST_HEAD) ? head_q : ent_q.link;

    always_ff @(posedge clk)
    begin
        head_q <= head_mem[job_in.job.slot[SLOT_W-1:0]];
        if (head_we)
        begin
            head_mem[slot] <= used_reg[PTR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        ent_q <= ent_mem[ent_ra];
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        fresh_next     = fresh_reg;
        tail_next      = tail_reg;
        used_next      = used_reg;
        head_ok_next   = head_ok_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ent_we         = 1'b0;
        ent_wa         = cur_reg;
        ent_wd         = ent_q;
        head_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                if (head_ok_reg[slot])
                begin
                    cur_next   = head_q;
                    state_next = ST_WALK;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    state_next     = ST_IDLE;
                    if (!is_lookup)
                    begin
                        if (pool_full)
                        begin
                            rsp_next.table_full = 1'b1;
                        end
                        else
                        begin
                            ent_we             = 1'b1;
                            ent_wa             = used_reg[PTR_W-1:0];
                            ent_wd             = new_ent;
                            head_we            = 1'b1;
                            head_ok_next[slot] = 1'b1;
                            used_next          = used_reg + 1'b1;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (hit)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next           = '0;
                    rsp_next.found     = 1'b1;
                    state_next         = ST_IDLE;
                    if (is_lookup)
                    begin
                        rsp_next.next_hop_out = ent_q.hop;
                    end
                    else
                    begin
                        ent_we     = 1'b1;
                        ent_wa     = cur_reg;
                        ent_wd     = ent_q;
                        ent_wd.hop = job_reg.req.next_hop_in;
                    end
                end
                else if (ent_q.link_ok)
                begin
                    cur_next = ent_q.link;
                end
                else
                begin
                    rsp_next = '0;
                    if (is_lookup || pool_full)
                    begin
                        rsp_valid_next      = 1'b1;
                        rsp_next.table_full = !is_lookup;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        ent_we     = 1'b1;
                        ent_wa     = used_reg[PTR_W-1:0];
                        ent_wd     = new_ent;
                        fresh_next = used_reg[PTR_W-1:0];
                        tail_next  = ent_q;
                        used_next  = used_reg + 1'b1;
                        state_next = ST_LINK;
                    end
                end
            end
            ST_LINK:
            begin
                ent_we         = 1'b1;
                ent_wa         = cur_reg;
                ent_wd         = tail_reg;
                ent_wd.link_ok = 1'b1;
                ent_wd.link    = fresh_reg;
                rsp_valid_next = 1'b1;
                rsp_next       = '0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job_in.job;
        end
        cur_reg   <= cur_next;
        fresh_reg <= fresh_next;
        tail_reg  <= tail_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            head_ok_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            head_ok_reg   <= head_ok_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/chrt_checker.sv @@
// chrt_checker: port-level assertions for chained_hash_route_table_core, with its bind
// depends on chrt_pkg and the top level's ports
`default_nettype none

module chrt_checker
    import chrt_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   req_valid,
    input  wire logic   req_ready,
    input  wire logic   rsp_valid,
    input  wire logic   rsp_ready,
    input  wire rsp_t   rsp
);

    logic [3:0] pending_reg;
    logic [3:0] pending_next;

    assign pending_next = pending_reg + 4'(req_valid && req_ready)
                          - 4'(rsp_valid && rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 4'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 4'd0)
        else $error("result without an outstanding request");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'd4)
        else $error("more requests in flight than the design can hold");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.found && rsp.table_full))
        else $error("full flagged on a found destination");

    a_hop_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.next_hop_out != '0) |-> rsp.found)
        else $error("next hop returned on a miss");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

endmodule

bind chained_hash_route_table_core chrt_checker u_chrt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
);

`default_nettype wire

@@ tb/chained_hash_route_table_core_tb.sv @@
// chained_hash_route_table_core_tb: self-checking bench for the chained hash route table
// depends on chrt_pkg and chained_hash_route_table_core; bursty sender, stalling receiver,
// in-bench route table predictor checked against every response transfer
module chained_hash_route_table_core_tb;
    import chrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int POOL_ENTRIES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct
    {
        req_t item;
        bit   wait_drain;
    } queued_req_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // predictor copy of the table
    bit                  head_live [SLOTS];
    int unsigned         head_idx  [SLOTS];
    logic [KEY_W-1:0]    pool_dest [POOL_ENTRIES];
    logic [HOP_W-1:0]    pool_hop  [POOL_ENTRIES];
    int unsigned         pool_link [POOL_ENTRIES];
    bit                  link_live [POOL_ENTRIES];
    int unsigned         pool_used = 0;

    queued_req_t         route_reqs[$];
    rsp_t                expected_hops[$];
    logic [KEY_W-1:0]    set_dests[$];

    bit                  req_taken  = 1'b0;
    int                  burst_left = 1;
    int                  gap_left   = 0;
    int                  rsp_seen   = 0;
    int                  hold_left  = 0;
    bit                  hold_done  = 1'b0;
    int                  mode_left  = 0;
    int                  ready_mode = 0;
    int                  errors     = 0;
    int                  cycles     = 0;
    rsp_t                want;

    chained_hash_route_table_core #(
        .SLOTS        (SLOTS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    function automatic rsp_t resolve_route(req_t r);
        int unsigned slot;
        int unsigned cur;
        int unsigned tail;
        int unsigned hit;
        int unsigned steps;
        bit          live;
        bit          has_tail;
        bit          present;
        rsp_t        res;
        slot     = r.dest_node % SLOTS;
        live     = head_live[slot];
        cur      = head_idx[slot];
        present  = 1'b0;
        has_tail = 1'b0;
        tail     = 0;
        hit      = 0;
        steps    = 0;
        while (live && steps < POOL_ENTRIES && cur < POOL_ENTRIES && !present)
        begin
            if (pool_dest[cur] == r.dest_node)
            begin
                present = 1'b1;
                hit     = cur;
            end
            else
            begin
                tail     = cur;
                has_tail = 1'b1;
                live     = link_live[cur];
                cur      = pool_link[cur];
                steps++;
            end
        end
        res       = '0;
        res.found = present;
        if (op_t'(r.operation) == OP_LOOKUP)
        begin
            if (present)
                res.next_hop_out = pool_hop[hit];
        end
        else if (present)
            pool_hop[hit] = r.next_hop_in;
        else if (pool_used >= POOL_ENTRIES)
            res.table_full = 1'b1;
        else
        begin
            pool_dest[pool_used] = r.dest_node;
            pool_hop[pool_used]  = r.next_hop_in;
            pool_link[pool_used] = 0;
            link_live[pool_used] = 1'b0;
            if (has_tail)
            begin
                pool_link[tail] = pool_used;
                link_live[tail] = 1'b1;
            end
            else
            begin
                head_idx[slot]  = pool_used;
                head_live[slot] = 1'b1;
            end
            pool_used++;
        end
        return res;
    endfunction

    task automatic queue_req(op_t op, logic [KEY_W-1:0] dest, logic [HOP_W-1:0] hop,
                             bit drain);
        queued_req_t q;
        q.item.operation   = op;
        q.item.dest_node   = dest;
        q.item.next_hop_in = hop;
        q.wait_drain       = drain;
        route_reqs.push_back(q);
        if (op == OP_SET)
            set_dests.push_back(dest);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (route_reqs.size() != 0 &&
                         !(route_reqs[0].wait_drain && expected_hops.size() != 0))
                begin
                    req       <= route_reqs[0].item;
                    req_valid <= 1'b1;
                    void'(route_reqs.pop_front());
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
            req_taken = 1'b0;
        end
    end

    // response stall pattern, with one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && rsp_seen >= 400)
            begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(8, 80);
                end
                mode_left--;
                case (ready_mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 1) == 1);
                    default: rsp_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                expected_hops.push_back(resolve_route(req));
                req_taken = 1'b1;
            end
            if (rsp_valid && rsp_ready)
            begin
                rsp_seen++;
                if (expected_hops.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = expected_hops.pop_front();
                    if (rsp.next_hop_out !== want.next_hop_out)
                    begin
                        $display("%0t: next_hop_out expected %0d actual %0d",
                                 $time, want.next_hop_out, rsp.next_hop_out);
                        errors++;
                    end
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.table_full !== want.table_full)
                    begin
                        $display("%0t: table_full expected %0b actual %0b",
                                 $time, want.table_full, rsp.table_full);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned      pick;
        logic [3:0]       hot_slot;
        logic [KEY_W-1:0] dest;
        op_t              op;
        hot_slot = 4'($urandom_range(0, 15));

        // empty table, both extremes of key and hop
        queue_req(OP_LOOKUP, 8'h00, 8'h5a, 1'b0);
        queue_req(OP_SET,    8'h00, 8'hff, 1'b0);
        queue_req(OP_SET,    8'hff, 8'h00, 1'b0);
        queue_req(OP_LOOKUP, 8'h00, 8'h00, 1'b0);
        queue_req(OP_LOOKUP, 8'hff, 8'hff, 1'b0);
        // chain in slot zero
        queue_req(OP_SET,    8'h10, 8'h11, 1'b0);
        queue_req(OP_SET,    8'h20, 8'h22, 1'b0);
        queue_req(OP_SET,    8'h30, 8'h33, 1'b0);
        queue_req(OP_LOOKUP, 8'h30, 8'h00, 1'b0);
        queue_req(OP_LOOKUP, 8'h40, 8'h00, 1'b0);
        queue_req(OP_SET,    8'h20, 8'ha5, 1'b0);
        queue_req(OP_LOOKUP, 8'h20, 8'h00, 1'b0);
        queue_req(OP_SET,    8'h00, 8'h5a, 1'b0);
        queue_req(OP_LOOKUP, 8'h00, 8'h00, 1'b0);
        queue_req(OP_SET,    8'h40, 8'h44, 1'b0);
        queue_req(OP_LOOKUP, 8'h40, 8'hff, 1'b0);
        // miss behind a non-empty slot
        queue_req(OP_LOOKUP, 8'hef, 8'h00, 1'b0);
        queue_req(OP_SET,    8'h0f, 8'hf0, 1'b0);
        queue_req(OP_LOOKUP, 8'h0f, 8'h00, 1'b0);
        queue_req(OP_LOOKUP, 8'h80, 8'h00, 1'b0);
        queue_req(OP_SET,    8'h80, 8'h7f, 1'b0);
        queue_req(OP_LOOKUP, 8'h80, 8'h00, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                dest = set_dests[$urandom_range(0, set_dests.size() - 1)];
            else if (pick < 70)
                dest = {4'($urandom_range(0, 15)), hot_slot};
            else
                dest = 8'($urandom_range(0, 255));
            op = ($urandom_range(0, 99) < 45) ? OP_LOOKUP : OP_SET;
            queue_req(op, dest, 8'($urandom_range(0, 255)), i == 0 || i == 900);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (route_reqs.size() != 0 || req_valid || expected_hops.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0 && expected_hops.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/chrt_pkg.sv
rtl/chrt_front.sv
rtl/chrt_back.sv
rtl/chained_hash_route_table_core.sv
rtl/chrt_checker.sv
tb/chained_hash_route_table_core_tb.sv
